// ===== rtl/core/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg
// Types, codes and saturation helpers shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_EQ  = 3'd4;
    localparam logic [2:0] OP_NE  = 3'd5;
    localparam logic [2:0] OP_MOD = 3'd6;

    // Quotient bits produced by the cell row, one per cell.
    localparam int QW     = 34;
    localparam int NCELL  = QW;
    // Square root datapath: radicand padded to two bits per cell.
    localparam int SQ_VW  = 2 * NCELL;
    localparam int SQ_RW  = 35;
    localparam int SQ_QW  = 34;

    localparam logic [65:0] SAT_BIG = {1'b1, 65'd0};

    typedef enum logic [1:0] {
        K_DIRECT,
        K_MUL,
        K_DIV,
        K_SQRT
    } t_kind;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_req;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               is_true;
        logic               div_by_zero;
    } t_res;

    typedef struct packed {
        logic               vld;
        t_kind              kind;
        logic [31:0]        dir_re;
        logic [31:0]        dir_im;
        logic               is_true;
        logic               dz;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] p3;
        logic signed [63:0] p4;
        logic signed [63:0] d1;
        logic signed [63:0] d2;
    } t_prod;

    typedef struct packed {
        logic               vld;
        t_kind              kind;
        logic [31:0]        dir_re;
        logic [31:0]        dir_im;
        logic               is_true;
        logic               dz;
        logic signed [64:0] s_re;
        logic signed [64:0] s_im;
        logic [63:0]        den;
    } t_sum;

    typedef struct packed {
        logic               vld;
        t_kind              kind;
        logic [31:0]        dir_re;
        logic [31:0]        dir_im;
        logic               is_true;
        logic               dz;
        logic               neg_re;
        logic               neg_im;
        logic               ovf_re;
        logic               ovf_im;
        logic [63:0]        mag_re;
        logic [63:0]        mag_im;
        logic [63:0]        den;
        logic [63:0]        rem_re;
        logic [63:0]        rem_im;
        logic [QW-1:0]      lo_re;
        logic [QW-1:0]      lo_im;
        logic [SQ_RW-1:0]   sq_rem;
        logic [SQ_QW-1:0]   sq_root;
        logic [SQ_VW-1:0]   sq_v;
    } t_cell;

    // Saturate a sign and magnitude pair to the signed 32-bit range.
    function automatic logic [31:0] sat_sm(input logic neg, input logic [65:0] m);
        logic [31:0] r;
        if (!neg) begin
            r = (m > 66'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        end else begin
            r = (m >= 66'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
        end
        return r;
    endfunction

    function automatic logic [31:0] sat33(input logic [32:0] s);
        logic [31:0] r;
        if (s[32] != s[31]) begin
            r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex-number ALU on signed fixed-point operands.
// ----------------------------------------------------------------------------
// The unit takes one item in every cycle and never raises busy. Each item
// passes through four front stages (input, products, sums, divider set-up),
// a row of 34 cells that each produce one quotient bit of both dividers and
// one square root bit, and the result register. The row length is set by
// the 34 quotient bits needed to decide saturation. The result is shown for
// one cycle with o_valid and cannot be held off.
module complex_arith_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cal_pkg::t_req i_req,
    output logic          o_valid,
    output cal_pkg::t_res o_res
);
    import cal_pkg::*;

    localparam int LATENCY = NCELL + 5;

    t_cell chain [NCELL+1];

    assign busy = 1'b0;

    cal_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (start && !busy),
        .i_req   (i_req),
        .o_cell  (chain[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        cal_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    cal_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (chain[NCELL]),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("item result did not appear at the fixed latency");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.is_true) |-> (o_res.res_re == 32'sd0 && o_res.res_im == 32'sd0))
        else $error("compare result carries nonzero value");

    a_dz_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.div_by_zero) |-> !o_res.is_true)
        else $error("divide by zero flagged together with compare outcome");

endmodule

// ===== rtl/core/cal_front.sv =====
// ----------------------------------------------------------------------------
// cal_front
// Input register, operand products, sums and set-up of the cell row.
// ----------------------------------------------------------------------------
module cal_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  cal_pkg::t_req i_req,
    output cal_pkg::t_cell o_cell
);
    import cal_pkg::*;

    localparam int NW = 64 + FRAC_BITS + 1;

    logic  r_a_vld;
    t_req  r_a;
    t_prod r_b, n_b;
    t_sum  r_c, n_c;
    t_cell r_d, n_d;

    logic signed [31:0] yr, yi;
    logic [32:0]        add_re, add_im, sub_re, sub_im;
    logic               bz, eq;
    logic [NW-1:0]      num_re, num_im;
    logic [NW-QW-1:0]   hi_re, hi_im;
    logic [64:0]        ab_re, ab_im;

    always_comb begin
        yr = (r_a.req_type == OP_MOD) ? r_a.a_re : r_a.b_re;
        yi = (r_a.req_type == OP_MOD) ? r_a.a_im : r_a.b_im;
        add_re = {r_a.a_re[31], r_a.a_re} + {r_a.b_re[31], r_a.b_re};
        add_im = {r_a.a_im[31], r_a.a_im} + {r_a.b_im[31], r_a.b_im};
        sub_re = {r_a.a_re[31], r_a.a_re} - {r_a.b_re[31], r_a.b_re};
        sub_im = {r_a.a_im[31], r_a.a_im} - {r_a.b_im[31], r_a.b_im};
        bz = (r_a.b_re == 32'sd0) && (r_a.b_im == 32'sd0);
        eq = (r_a.a_re == r_a.b_re) && (r_a.a_im == r_a.b_im);

        n_b.vld = r_a_vld;
        n_b.p1 = r_a.a_re * yr;
        n_b.p2 = r_a.a_im * yi;
        n_b.p3 = r_a.a_im * r_a.b_re;
        n_b.p4 = r_a.a_re * r_a.b_im;
        n_b.d1 = r_a.b_re * r_a.b_re;
        n_b.d2 = r_a.b_im * r_a.b_im;
        n_b.kind = K_DIRECT;
        n_b.dir_re = 32'd0;
        n_b.dir_im = 32'd0;
        n_b.is_true = 1'b0;
        n_b.dz = 1'b0;
        case (r_a.req_type)
            OP_ADD: begin
                n_b.dir_re = sat33(add_re);
                n_b.dir_im = sat33(add_im);
            end
            OP_SUB: begin
                n_b.dir_re = sat33(sub_re);
                n_b.dir_im = sat33(sub_im);
            end
            OP_MUL: n_b.kind = K_MUL;
            OP_DIV: begin
                if (bz) begin
                    n_b.dir_re = r_a.a_re;
                    n_b.dir_im = r_a.a_im;
                    n_b.dz = 1'b1;
                end else begin
                    n_b.kind = K_DIV;
                end
            end
            OP_EQ:  n_b.is_true = eq;
            OP_NE:  n_b.is_true = !eq;
            OP_MOD: n_b.kind = K_SQRT;
            default: n_b.kind = K_DIRECT;
        endcase
    end

    // One shared adder per lane; multiply, divide and modulus pick the signs.
    always_comb begin
        n_c.vld = r_b.vld;
        n_c.kind = r_b.kind;
        n_c.dir_re = r_b.dir_re;
        n_c.dir_im = r_b.dir_im;
        n_c.is_true = r_b.is_true;
        n_c.dz = r_b.dz;
        if (r_b.kind == K_MUL) begin
            n_c.s_re = 65'(r_b.p1) - 65'(r_b.p2);
            n_c.s_im = 65'(r_b.p3) + 65'(r_b.p4);
        end else begin
            n_c.s_re = 65'(r_b.p1) + 65'(r_b.p2);
            n_c.s_im = 65'(r_b.p3) - 65'(r_b.p4);
        end
        n_c.den = r_b.d1 + r_b.d2;
    end

    // Magnitudes, and the initial remainder and dividend bits of each divider.
    always_comb begin
        ab_re = r_c.s_re[64] ? (65'd0 - r_c.s_re) : r_c.s_re;
        ab_im = r_c.s_im[64] ? (65'd0 - r_c.s_im) : r_c.s_im;
        num_re = {ab_re[63:0], {(FRAC_BITS + 1){1'b0}}};
        num_im = {ab_im[63:0], {(FRAC_BITS + 1){1'b0}}};
        hi_re = num_re[NW-1:QW];
        hi_im = num_im[NW-1:QW];

        n_d.vld = r_c.vld;
        n_d.kind = r_c.kind;
        n_d.dir_re = r_c.dir_re;
        n_d.dir_im = r_c.dir_im;
        n_d.is_true = r_c.is_true;
        n_d.dz = r_c.dz;
        n_d.neg_re = r_c.s_re[64];
        n_d.neg_im = r_c.s_im[64];
        n_d.mag_re = ab_re[63:0];
        n_d.mag_im = ab_im[63:0];
        n_d.den = r_c.den;
        n_d.rem_re = 64'(hi_re);
        n_d.rem_im = 64'(hi_im);
        // A quotient that does not fit the cell row saturates anyway.
        n_d.ovf_re = 64'(hi_re) >= r_c.den;
        n_d.ovf_im = 64'(hi_im) >= r_c.den;
        n_d.lo_re = num_re[QW-1:0];
        n_d.lo_im = num_im[QW-1:0];
        n_d.sq_rem = '0;
        n_d.sq_root = '0;
        n_d.sq_v = SQ_VW'(ab_re[63:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b <= '0;
            r_c <= '0;
            r_d <= '0;
        end else begin
            r_a_vld <= i_load;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_req;
        end
    end

    assign o_cell = r_d;

endmodule

// ===== rtl/core/cal_cell.sv =====
// ----------------------------------------------------------------------------
// cal_cell
// One step of the cell row: a quotient bit on each divider and a root bit.
// ----------------------------------------------------------------------------
module cal_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cal_pkg::t_cell i_cell,
    output cal_pkg::t_cell o_cell
);
    import cal_pkg::*;

    t_cell r_cell, n_cell;

    logic [64:0]        sh_re, sh_im, df_re, df_im;
    logic               ge_re, ge_im, ge_sq;
    logic [SQ_RW+1:0]   sq_t, sq_trial, sq_df;

    always_comb begin
        sh_re = {i_cell.rem_re, i_cell.lo_re[QW-1]};
        sh_im = {i_cell.rem_im, i_cell.lo_im[QW-1]};
        df_re = sh_re - {1'b0, i_cell.den};
        df_im = sh_im - {1'b0, i_cell.den};
        ge_re = sh_re >= {1'b0, i_cell.den};
        ge_im = sh_im >= {1'b0, i_cell.den};

        sq_t = {i_cell.sq_rem, i_cell.sq_v[SQ_VW-1:SQ_VW-2]};
        sq_trial = {1'b0, i_cell.sq_root, 2'b01};
        sq_df = sq_t - sq_trial;
        ge_sq = sq_t >= sq_trial;

        n_cell = i_cell;
        n_cell.rem_re = ge_re ? df_re[63:0] : sh_re[63:0];
        n_cell.rem_im = ge_im ? df_im[63:0] : sh_im[63:0];
        // Dividend bits leave at the top while quotient bits enter below.
        n_cell.lo_re = {i_cell.lo_re[QW-2:0], ge_re};
        n_cell.lo_im = {i_cell.lo_im[QW-2:0], ge_im};
        n_cell.sq_rem = ge_sq ? sq_df[SQ_RW-1:0] : sq_t[SQ_RW-1:0];
        n_cell.sq_root = {i_cell.sq_root[SQ_QW-2:0], ge_sq};
        n_cell.sq_v = {i_cell.sq_v[SQ_VW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== rtl/core/cal_back.sv =====
// ----------------------------------------------------------------------------
// cal_back
// Final rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module cal_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cal_pkg::t_cell i_cell,
    output logic           o_valid,
    output cal_pkg::t_res  o_res
);
    import cal_pkg::*;

    localparam logic [65:0] HALF = 66'd1 << (FRAC_BITS - 1);

    logic        r_valid;
    t_res        r_res, n_res;
    logic [65:0] ml_re, ml_im, qr_re, qr_im, rt;

    always_comb begin
        ml_re = ({2'b00, i_cell.mag_re} + HALF) >> FRAC_BITS;
        ml_im = ({2'b00, i_cell.mag_im} + HALF) >> FRAC_BITS;
        qr_re = (66'(i_cell.lo_re) + 66'd1) >> 1;
        qr_im = (66'(i_cell.lo_im) + 66'd1) >> 1;
        if (i_cell.ovf_re) begin
            qr_re = SAT_BIG;
        end
        if (i_cell.ovf_im) begin
            qr_im = SAT_BIG;
        end
        // Round the root up when the remainder exceeds the root.
        rt = 66'(i_cell.sq_root) + 66'(66'(i_cell.sq_rem) > 66'(i_cell.sq_root));

        n_res.is_true = i_cell.is_true;
        n_res.div_by_zero = i_cell.dz;
        case (i_cell.kind)
            K_MUL: begin
                n_res.res_re = sat_sm(i_cell.neg_re, ml_re);
                n_res.res_im = sat_sm(i_cell.neg_im, ml_im);
            end
            K_DIV: begin
                n_res.res_re = sat_sm(i_cell.neg_re, qr_re);
                n_res.res_im = sat_sm(i_cell.neg_im, qr_im);
            end
            K_SQRT: begin
                n_res.res_re = sat_sm(1'b0, rt);
                n_res.res_im = 32'sd0;
            end
            default: begin
                n_res.res_re = i_cell.dir_re;
                n_res.res_im = i_cell.dir_im;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cell.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res = r_res;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives directed and random complex operations into the unit with random
// gaps, predicts every result with an exact wide-integer model and checks
// each strobed result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
    import cal_pkg::*;

    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 1950;
    localparam int CYC_LIMIT = 200000;

    // Selector value with no operation behind it.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct {
        t_req req;
        bit   drain;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_valid;
    t_res o_res;

    complex_arith_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always #5 i_clk = ~i_clk;

    t_pending pending_items[$];
    t_res     expected_res[$];
    int       n_errors = 0;
    int       n_checked = 0;
    int       n_cycles = 0;
    int       op_count[8];
    int       n_div_zero = 0;
    bit       sent_last = 1'b0;
    int       gap_left = 0;
    bit       gappy = 1'b1;
    int       n_sent = 0;

    // Clamps an exact value to the signed 32-bit range.
    function automatic logic [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -128'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Drops the fraction bits of a product, rounding half away from zero.
    function automatic logic signed [127:0] rescale(input logic signed [127:0] v);
        logic [127:0] m;
        m = (v < 0) ? -v : v;
        m = (m + (128'd1 << (FRAC - 1))) >> FRAC;
        return (v < 0) ? -$signed(m) : $signed(m);
    endfunction

    // Rounded quotient num * 2^FRAC / den; large quotients are capped and
    // saturate afterwards anyway.
    function automatic logic signed [127:0] fix_div(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
        logic [127:0] m;
        logic [127:0] q;
        m = (num < 0) ? -num : num;
        q = (m << (FRAC + 1)) / den;
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        q = (q + 1) >> 1;
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [127:0] round_root(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int i = 32; i >= 0; i--) begin
            c = r | (128'd1 << i);
            if (c * c <= v) r = c;
        end
        if (v - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic t_res complex_result(input t_req q);
        t_res r;
        logic signed [127:0] ar, ai, br, bi, den;
        ar = q.a_re;
        ai = q.a_im;
        br = q.b_re;
        bi = q.b_im;
        r = '0;
        case (q.req_type)
            OP_ADD: begin
                r.res_re = clamp32(ar + br);
                r.res_im = clamp32(ai + bi);
            end
            OP_SUB: begin
                r.res_re = clamp32(ar - br);
                r.res_im = clamp32(ai - bi);
            end
            OP_MUL: begin
                r.res_re = clamp32(rescale(ar * br - ai * bi));
                r.res_im = clamp32(rescale(ai * br + ar * bi));
            end
            OP_DIV: begin
                if (br == 0 && bi == 0) begin
                    r.res_re = q.a_re;
                    r.res_im = q.a_im;
                    r.div_by_zero = 1'b1;
                end else begin
                    den = br * br + bi * bi;
                    r.res_re = clamp32(fix_div(ar * br + ai * bi, den));
                    r.res_im = clamp32(fix_div(ai * br - ar * bi, den));
                end
            end
            OP_EQ: r.is_true = (ar == br && ai == bi);
            OP_NE: r.is_true = !(ar == br && ai == bi);
            OP_MOD: r.res_re = clamp32(round_root(ar * ar + ai * ai));
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 3) - 1;
            3, 4: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            5: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic [2:0] op, input logic [31:0] ar,
                              input logic [31:0] ai, input logic [31:0] br,
                              input logic [31:0] bi, input bit drain);
        t_pending p;
        p.req.req_type = op;
        p.req.a_re = ar;
        p.req.a_im = ai;
        p.req.b_re = br;
        p.req.b_im = bi;
        p.drain = drain;
        pending_items.push_back(p);
    endtask

    // Driver: the current item stays on the bus until the unit takes it.
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !sent_last)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         (!pending_items[0].drain ||
                          (expected_res.size() == 0 && !start))) begin
                i_req <= pending_items[0].req;
                pending_items.pop_front();
                start <= 1'b1;
                n_sent = n_sent + 1;
                if (n_sent % 150 == 0) gappy = ~gappy;
                gap_left <= gappy ? $urandom_range(0, 7) : 0;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predicts on acceptance and checks every strobed result.
    always @(posedge i_clk) begin
        t_res exp_r;
        n_cycles = n_cycles + 1;
        if (n_cycles > CYC_LIMIT) begin
            $display("Timeout after %0d cycles", n_cycles);
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n) begin
            sent_last <= start && !busy;
            if (o_valid) begin
                if (expected_res.size() == 0) begin
                    n_errors = n_errors + 1;
                    if (n_errors <= 10) $display("Unexpected result %h", o_res);
                end else begin
                    exp_r = expected_res.pop_front();
                    n_checked = n_checked + 1;
                    if (o_res !== exp_r) begin
                        n_errors = n_errors + 1;
                        if (n_errors <= 10)
                            $display("Mismatch re %h/%h im %h/%h true %b/%b dz %b/%b (exp/got)",
                                     exp_r.res_re, o_res.res_re, exp_r.res_im,
                                     o_res.res_im, exp_r.is_true, o_res.is_true,
                                     exp_r.div_by_zero, o_res.div_by_zero);
                    end
                end
            end
            if (start && !busy) begin
                exp_r = complex_result(i_req);
                expected_res.push_back(exp_r);
                op_count[i_req.req_type] = op_count[i_req.req_type] + 1;
                if (exp_r.div_by_zero) n_div_zero = n_div_zero + 1;
            end
        end
    end

    initial begin
        logic [31:0] ar, ai, br, bi;
        logic [2:0] op;
        int w;
        // Directed part: extremes, every operation, divide by zero, ties.
        queue_item(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        queue_item(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        queue_item(OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 0);
        queue_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        queue_item(OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        queue_item(OP_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0, 0);
        queue_item(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0, 0);
        queue_item(OP_DIV, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0, 0);
        queue_item(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0, 0);
        queue_item(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        queue_item(OP_DIV, 32'h0000_0001, 32'h0, 32'h0002_0000, 32'h0, 0);
        queue_item(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 0);
        queue_item(OP_EQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        queue_item(OP_EQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE, 0);
        queue_item(OP_NE, 32'h1, 32'h2, 32'h1, 32'h2, 0);
        queue_item(OP_NE, 32'h1, 32'h2, 32'h3, 32'h2, 0);
        queue_item(OP_MOD, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        queue_item(OP_MOD, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0, 0);
        queue_item(OP_MOD, 32'h0, 32'h0, 32'h0, 32'h0, 0);
        queue_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < N_RANDOM; i++) begin
            op = 3'($urandom_range(0, 7));
            ar = pick_operand();
            ai = pick_operand();
            br = pick_operand();
            bi = pick_operand();
            w = $urandom_range(0, 9);
            if ((op == OP_EQ || op == OP_NE) && w < 5) begin
                br = ar;
                bi = (w < 3) ? ai : ai ^ (32'd1 << $urandom_range(0, 31));
            end
            if (op == OP_DIV && w < 2) begin
                br = 0;
                bi = 0;
            end
            queue_item(op, ar, ai, br, bi, (i == 700 || i == 1400));
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (start || expected_res.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Checked %0d results: add %0d sub %0d mul %0d div %0d (by zero %0d)",
                 n_checked, op_count[0], op_count[1], op_count[2], op_count[3],
                 n_div_zero);
        $display("eq %0d ne %0d mod %0d unused %0d, errors %0d",
                 op_count[4], op_count[5], op_count[6], op_count[7], n_errors);
        if (n_errors == 0 && expected_res.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
